// File: rtl/gfmd_pkg.sv
// ----------------------------------------------------------------------------
// gfmd_pkg
// Shared constants and types for the GF(2^m) multiply/divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gfmd_pkg;

    // Element and polynomial widths at the ports
    localparam int ELEM_W          = 16;
    localparam int POLY_W          = 17;

    // Default field size and reset polynomial x^16+x^12+x^3+x+1
    localparam int FIELD_BITS_DEF  = 16;
    localparam logic [POLY_W-1:0] POLY_RESET = 17'd69643;

    // Operation codes carried in the kind field
    localparam logic KIND_MUL = 1'b0;
    localparam logic KIND_DIV = 1'b1;

    // Entries in the output queue
    localparam int OUT_DEPTH       = 4;

    // One result transaction
    typedef struct packed {
        logic [ELEM_W-1:0] field_result;
        logic              divide_by_zero;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/gfmd_if.sv
// ----------------------------------------------------------------------------
// gfmd_if
// Valid/ready channels of the GF(2^m) unit: operation in, result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfmd_op_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [gfmd_pkg::ELEM_W-1:0]   operand_a;
    logic [gfmd_pkg::ELEM_W-1:0]   operand_b;

    modport source (output valid, output kind, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input kind, input operand_a, input operand_b,
                    output ready);
endinterface

interface gfmd_res_if;
    logic                          valid;
    logic                          ready;
    logic [gfmd_pkg::ELEM_W-1:0]   field_result;
    logic                          divide_by_zero;

    modport source (output valid, output field_result, output divide_by_zero,
                    input ready);
    modport sink   (input valid, input field_result, input divide_by_zero,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/gfmd_out_fifo.sv
// ----------------------------------------------------------------------------
// gfmd_out_fifo
// Small result queue that decouples the lookup pipeline from the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module gfmd_out_fifo #(
    parameter int DEPTH = gfmd_pkg::OUT_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire gfmd_pkg::t_result i_push_data,
    gfmd_res_if.source             o_res
);
    import gfmd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result               r_mem [DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr;
    logic [PTR_W-1:0]      r_rd_ptr;
    logic [CNT_W-1:0]      r_count;
    logic                  pop;
    t_result               head;

    assign pop  = o_res.valid && o_res.ready;
    assign head = r_mem[r_rd_ptr];

    assign o_res.valid          = (r_count != '0);
    assign o_res.field_result   = head.field_result;
    assign o_res.divide_by_zero = head.divide_by_zero;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/gf16_mul_div_unit.sv
// An accepted operation reaches o_res via the log read, antilog read and output queue registers.
// Throughput: one transaction per cycle while i_op.ready is high; the log store is read at both
// operands in one cycle and the antilog store once in the next, so lookups overlap freely
// between transactions. A four-entry output queue with credit count keeps input acceptance going
// while a result waits. Reset and every polynomial write start a table build of 2^FIELD_BITS-1 entries
// (65535 at 16 bits), one log and one antilog entry per cycle; i_op.ready stays low until it finishes.
// ----------------------------------------------------------------------------
// gf16_mul_div_unit
// GF(2^m) multiply/divide through log and antilog tables held in two
// synchronous memories, built in hardware from the configured polynomial.
// ----------------------------------------------------------------------------
`default_nettype none

module gf16_mul_div_unit #(
    parameter int FIELD_BITS = gfmd_pkg::FIELD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [gfmd_pkg::POLY_W-1:0]  i_cfg_wdata,
    gfmd_op_if.sink                           i_op,
    gfmd_res_if.source                        o_res
);
    import gfmd_pkg::*;

    localparam int TBL_DEPTH = 1 << FIELD_BITS;
    localparam logic [FIELD_BITS-1:0] ORDER_E = '1;
    localparam logic [FIELD_BITS:0]   ORDER_X = {1'b0, ORDER_E};
    localparam int CRD_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic {ST_BUILD, ST_RUN} t_state;

    // Build sequencer and configuration
    t_state                 r_state;
    logic [POLY_W-1:0]      r_poly;
    logic [FIELD_BITS-1:0]  r_idx;
    logic [FIELD_BITS-1:0]  r_cur;
    logic [FIELD_BITS-1:0]  n_cur;
    logic [FIELD_BITS:0]    shifted;
    logic                   build_we;

    // Memories
    logic [FIELD_BITS-1:0]  log_mem [TBL_DEPTH];
    logic [FIELD_BITS-1:0]  pow_mem [TBL_DEPTH];
    logic [FIELD_BITS-1:0]  r_log_a;
    logic [FIELD_BITS-1:0]  r_log_b;
    logic [FIELD_BITS-1:0]  r_pow_q;

    // Pipeline
    logic                   op_acc;
    logic                   res_acc;
    logic [FIELD_BITS-1:0]  op_a;
    logic [FIELD_BITS-1:0]  op_b;
    logic                   r_s1_valid;
    logic                   r_s1_kind;
    logic                   r_s1_za;
    logic                   r_s1_zb;
    logic                   r_s2_valid;
    logic                   r_s2_zero;
    logic                   r_s2_dz;
    logic [FIELD_BITS:0]    sum_x;
    logic [FIELD_BITS:0]    diff_x;
    logic [FIELD_BITS-1:0]  pow_idx;
    logic [CRD_W-1:0]       r_credit;
    t_result                push_data;

    assign build_we = (r_state == ST_BUILD);
    assign op_acc   = i_op.valid && i_op.ready;
    assign res_acc  = o_res.valid && o_res.ready;
    assign op_a     = i_op.operand_a[FIELD_BITS-1:0];
    assign op_b     = i_op.operand_b[FIELD_BITS-1:0];

    // Accept only with tables built and a free slot in the output queue
    assign i_op.ready = (r_state == ST_RUN) && (r_credit < CRD_W'(OUT_DEPTH));

    // Next power of alpha: shift and reduce, kept within the element width
    always_comb begin
        shifted = {r_cur, 1'b0};
        if (shifted[FIELD_BITS]) begin
            shifted = shifted ^ r_poly[FIELD_BITS:0];
        end
        n_cur = shifted[FIELD_BITS-1:0];
    end

    // Build state machine and polynomial register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_BUILD;
            r_poly  <= POLY_RESET;
            r_idx   <= '0;
            r_cur   <= FIELD_BITS'(1);
        end else if (i_cfg_we) begin
            r_state <= ST_BUILD;
            r_poly  <= i_cfg_wdata;
            r_idx   <= '0;
            r_cur   <= FIELD_BITS'(1);
        end else begin
            case (r_state)
                ST_BUILD: begin
                    r_idx <= r_idx + 1'b1;
                    r_cur <= n_cur;
                    if (r_idx == ORDER_E - 1'b1) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_state <= ST_RUN;
                end
                default: begin
                    r_state <= ST_BUILD;
                end
            endcase
        end
    end

    // Log store: written by the build, read at both operands
    always_ff @(posedge i_clk) begin
        if (build_we) begin
            log_mem[r_cur] <= r_idx;
        end
        if (op_acc) begin
            r_log_a <= log_mem[op_a];
            r_log_b <= log_mem[op_b];
        end
    end

    // Exponent arithmetic modulo 2^m-1
    always_comb begin
        sum_x  = {1'b0, r_log_a} + {1'b0, r_log_b};
        diff_x = {1'b0, r_log_a} - {1'b0, r_log_b};
        if (r_s1_kind == KIND_MUL) begin
            pow_idx = (sum_x >= ORDER_X) ? FIELD_BITS'(sum_x - ORDER_X)
                                         : sum_x[FIELD_BITS-1:0];
        end else begin
            pow_idx = diff_x[FIELD_BITS] ? diff_x[FIELD_BITS-1:0] + ORDER_E
                                         : diff_x[FIELD_BITS-1:0];
        end
    end

    // Antilog store: written by the build, read at the exponent
    always_ff @(posedge i_clk) begin
        if (build_we) begin
            pow_mem[r_idx] <= r_cur;
        end
        if (r_s1_valid) begin
            r_pow_q <= pow_mem[pow_idx];
        end
    end

    // Stage flags: zero operands and divide by zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= op_acc;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (op_acc) begin
            r_s1_kind <= i_op.kind;
            r_s1_za   <= (op_a == '0);
            r_s1_zb   <= (op_b == '0);
        end
        if (r_s1_valid) begin
            r_s2_zero <= r_s1_za || r_s1_zb;
            r_s2_dz   <= (r_s1_kind == KIND_DIV) && r_s1_zb;
        end
    end

    // Items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            case ({op_acc, res_acc})
                2'b10:   r_credit <= r_credit + 1'b1;
                2'b01:   r_credit <= r_credit - 1'b1;
                default: r_credit <= r_credit;
            endcase
        end
    end

    // Result assembly into the output queue
    always_comb begin
        push_data.field_result   = r_s2_zero ? '0 : ELEM_W'(r_pow_q);
        push_data.divide_by_zero = r_s2_dz;
    end

    gfmd_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s2_valid),
        .i_push_data (push_data),
        .o_res       (o_res)
    );

    // Outstanding transactions never exceed the queue size
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CRD_W'(OUT_DEPTH))
        else $error("credit count exceeds output queue depth");

    // An accepted transaction reaches the queue write through the stage one and stage two valid registers
    a_pipe_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op_acc |=> ##1 r_s2_valid)
        else $error("accepted transaction lost in lookup pipeline");

    // Divide by zero always returns a zero element
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.divide_by_zero) |-> (o_res.field_result == '0))
        else $error("divide by zero with nonzero result");

endmodule

`default_nettype wire
